// ===== src/rnb_pkg.sv =====
// Shared constants and types for the radial normal blend pipeline.
// No dependencies; the files that use it refer to it by scoped names.
package rnb_pkg;

  localparam int COORD_W  = 20;     // signed Q12.8 coordinate
  localparam int PIVOT_W  = 3 * COORD_W;
  localparam int NORM_W   = 16;     // signed Q1.14 component
  localparam int UNIT_ONE = 16384;  // 1.0 in Q1.14
  localparam int Q_W      = 15;     // quotient bits before clamping
  localparam int DIV_LAT  = Q_W + 1;

  // First normalization: per-group difference vector.
  localparam int MAG1_W = COORD_W;        // |v - p| magnitude
  localparam int SQS1_W = 2 * MAG1_W + 2; // sum of three squares
  localparam int SQ1_W  = SQS1_W + 16;    // sqrt operand
  localparam int L1_W   = SQ1_W / 2;
  localparam int N1_W   = MAG1_W + 22 + 1;

  // Second normalization: blended sum.
  localparam int SUM_W  = 18;             // up to four unit vectors
  localparam int MAG2_W = SUM_W - 1;
  localparam int SQS2_W = 2 * MAG2_W;
  localparam int SQ2_W  = SQS2_W + 20;
  localparam int L2_W   = SQ2_W / 2;
  localparam int N2_W   = MAG2_W + 24 + 1;

  localparam int LANE_LAT = 5 + L1_W + DIV_LAT;
  localparam int TOTAL_LAT = LANE_LAT + 6 + L2_W + DIV_LAT;

  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_GROUP_ENABLE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PIVOT_0      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PIVOT_1      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PIVOT_2      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PIVOT_3      = 3'd4;

  typedef struct packed {
    logic                   nz;
    logic [2:0]             sgn;
    logic [2:0][MAG1_W-1:0] mag;
  } lane_side_t;

  typedef struct packed {
    logic                   found;
    logic [2:0]             sgn;
    logic [2:0][MAG2_W-1:0] mag;
  } blend_side_t;

  typedef struct packed {
    logic nz;
    logic [2:0] sgn;
  } sign_side_t;

endpackage

// ===== src/radial_normal_blend_top.sv =====
// Radial normal blend, top level: config registers, group lanes, blend
// normalization and output buffer. Depends on rnb_pkg and all src modules.
//
// One vertex enters per clock while in_tready is high; its normal passes
// the group lanes, then the blend stage. Most of the latency lies in the
// two pipelined square-root units, which resolve one root bit per stage
// (29 and 27 stages), and in the clamped dividers (16 stages each), which
// resolve one quotient bit in each stage after the first. Every group has its
// own lane, so all groups work on the same vertex at once. A two-entry output
// buffer parts the pipeline from the result channel: in_tready drops only
// while both entries are held, and then the whole pipeline freezes without
// losing or repeating a transfer. The user must write configuration through
// cfg_we/cfg_index/cfg_wdata only while no vertex is in flight; the block
// does not enforce this. Writes to indexes above the last pivot are ignored.
module radial_normal_blend_top #(
  parameter int NUM_GROUPS  = 4,
  parameter int FIRST_GROUP = 0
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // Fields from bit 0 up: vertex_x[19:0], vertex_y[19:0], vertex_z[19:0],
  // face_groups[31:0], four zero bits.
  input  logic [95:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // Fields from bit 0 up: uses_radial, found, normal_x[15:0], normal_y[15:0],
  // normal_z[15:0], six zero bits.
  output logic [55:0] out_tdata,
  input  logic        cfg_we,
  input  logic [rnb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [59:0] cfg_wdata
);
  localparam int TL   = rnb_pkg::TOTAL_LAT;
  localparam int SW   = rnb_pkg::SUM_W;
  localparam int M2W  = rnb_pkg::MAG2_W;
  localparam int OUTW = 2 + 3 * rnb_pkg::NORM_W;

  // Configuration registers.
  logic [3:0]                  grp_en_r;
  logic [rnb_pkg::PIVOT_W-1:0] pivot_r [4];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grp_en_r <= '0;
      for (int g = 0; g < 4; g++) begin
        pivot_r[g] <= '0;
      end
    end else if (cfg_we) begin
      unique case (cfg_index)
        rnb_pkg::REG_GROUP_ENABLE: grp_en_r   <= cfg_wdata[3:0];
        rnb_pkg::REG_PIVOT_0:      pivot_r[0] <= cfg_wdata;
        rnb_pkg::REG_PIVOT_1:      pivot_r[1] <= cfg_wdata;
        rnb_pkg::REG_PIVOT_2:      pivot_r[2] <= cfg_wdata;
        rnb_pkg::REG_PIVOT_3:      pivot_r[3] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // The pipeline advances as a whole while the output buffer has room.
  logic [1:0] cnt_r;
  logic       en;
  assign en        = (cnt_r != 2'd2);
  assign in_tready = en;

  logic [TL-1:0] vld_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[TL-2:0], in_tvalid};
    end
  end

  // A group is active when it is enabled and its bit is set in the face mask.
  logic [NUM_GROUPS-1:0] active;
  logic                  uses_out;
  assign active = in_tdata[60+FIRST_GROUP +: NUM_GROUPS] & grp_en_r[NUM_GROUPS-1:0];

  rnb_delay #(.W(1), .D(TL)) u_uses (
    .clk(clk), .en(en), .d_i(|active), .d_o(uses_out)
  );

  logic signed [rnb_pkg::NORM_W-1:0] lane_u [NUM_GROUPS][3];

  for (genvar g = 0; g < NUM_GROUPS; g++) begin : g_lane
    rnb_group_lane u_lane (
      .clk(clk), .en(en), .act_i(active[g]),
      .vx_i(in_tdata[19:0]), .vy_i(in_tdata[39:20]), .vz_i(in_tdata[59:40]),
      .pivot_i(pivot_r[g]), .u_o(lane_u[g])
    );
  end

  // Blend: sum the unit vectors, then normalize the sum again.
  logic signed [SW-1:0]  s1_r [3];
  logic [M2W-1:0]        mag2_r [3];
  logic [2:0]            sgn2_r;
  logic                  found2_r;
  logic [2*M2W-1:0]      sq3_r [3];
  rnb_pkg::blend_side_t  side3_r;
  logic [rnb_pkg::SQS2_W-1:0] tsum4_r;
  rnb_pkg::blend_side_t  side4_r;
  rnb_pkg::blend_side_t  side_sq;
  logic [rnb_pkg::L2_W-1:0] len;

  always_ff @(posedge clk) begin
    logic signed [SW-1:0] acc;
    if (en) begin
      for (int c = 0; c < 3; c++) begin
        acc = '0;
        for (int g = 0; g < NUM_GROUPS; g++) begin
          acc = acc + SW'(lane_u[g][c]);
        end
        s1_r[c]   <= acc;
        sgn2_r[c] <= s1_r[c][SW-1];
        mag2_r[c] <= s1_r[c][SW-1] ? M2W'(-s1_r[c]) : s1_r[c][M2W-1:0];
        sq3_r[c]  <= mag2_r[c] * mag2_r[c];
        side3_r.mag[c] <= mag2_r[c];
      end
      found2_r      <= (s1_r[0] != '0) || (s1_r[1] != '0) || (s1_r[2] != '0);
      side3_r.sgn   <= sgn2_r;
      side3_r.found <= found2_r;
      tsum4_r <= rnb_pkg::SQS2_W'(sq3_r[0]) + rnb_pkg::SQS2_W'(sq3_r[1])
               + rnb_pkg::SQS2_W'(sq3_r[2]);
      side4_r <= side3_r;
    end
  end

  rnb_isqrt_pipe #(.W(rnb_pkg::SQ2_W)) u_sqrt (
    .clk(clk), .en(en), .x_i({tsum4_r, 20'd0}), .root_o(len)
  );

  rnb_delay #(.W($bits(rnb_pkg::blend_side_t)), .D(rnb_pkg::L2_W)) u_side (
    .clk(clk), .en(en), .d_i(side4_r), .d_o(side_sq)
  );

  logic [rnb_pkg::N2_W-1:0] num5_r [3];
  logic [rnb_pkg::L2_W-1:0] den5_r;
  rnb_pkg::sign_side_t      ss5_r;
  rnb_pkg::sign_side_t      ss_dv;
  logic [rnb_pkg::Q_W-1:0]  quo [3];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 3; c++) begin
        num5_r[c] <= rnb_pkg::N2_W'({side_sq.mag[c], 24'd0})
                   + rnb_pkg::N2_W'(len[rnb_pkg::L2_W-1:1]);
      end
      den5_r    <= len;
      ss5_r.nz  <= side_sq.found;
      ss5_r.sgn <= side_sq.sgn;
    end
  end

  for (genvar c = 0; c < 3; c++) begin : g_div
    rnb_div_pipe #(.NW(rnb_pkg::N2_W), .DW(rnb_pkg::L2_W)) u_div (
      .clk(clk), .en(en), .num_i(num5_r[c]), .den_i(den5_r), .quo_o(quo[c])
    );
  end

  rnb_delay #(.W($bits(rnb_pkg::sign_side_t)), .D(rnb_pkg::DIV_LAT)) u_sgn (
    .clk(clk), .en(en), .d_i(ss5_r), .d_o(ss_dv)
  );

  logic signed [rnb_pkg::NORM_W-1:0] n6_r [3];
  logic                              found6_r;

  always_ff @(posedge clk) begin
    logic signed [rnb_pkg::NORM_W-1:0] q;
    if (en) begin
      for (int c = 0; c < 3; c++) begin
        q = signed'(rnb_pkg::NORM_W'(quo[c]));
        n6_r[c] <= !ss_dv.nz ? '0 : (ss_dv.sgn[c] ? -q : q);
      end
      found6_r <= ss_dv.nz;
    end
  end

  // Two-entry output buffer. The item in the last stage is pushed at the
  // edge where it would otherwise shift out.
  logic [OUTW-1:0] buf_r [2];
  logic            wr_ptr_r;
  logic            rd_ptr_r;
  logic            push;
  logic            pop;

  assign push = en && vld_r[TL-1];
  assign pop  = out_tvalid && out_tready;

  always_ff @(posedge clk) begin
    if (push) begin
      buf_r[wr_ptr_r] <= {n6_r[2], n6_r[1], n6_r[0], found6_r, uses_out};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= '0;
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop)  rd_ptr_r <= ~rd_ptr_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

  assign out_tvalid = (cnt_r != 2'd0);
  assign out_tdata  = {6'd0, buf_r[rd_ptr_r]};
endmodule

// ===== src/rnb_delay.sv =====
// Enable-gated delay line for side data that rides along a pipeline.
// Depends on nothing.
module rnb_delay #(
  parameter int W = 8,
  parameter int D = 4
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] d_i,
  output logic [W-1:0] d_o
);
  logic [W-1:0] tap_r [D];

  always_ff @(posedge clk) begin
    if (en) begin
      tap_r[0] <= d_i;
      for (int k = 1; k < D; k++) begin
        tap_r[k] <= tap_r[k-1];
      end
    end
  end

  assign d_o = tap_r[D-1];
endmodule

// ===== src/rnb_isqrt_pipe.sv =====
// Pipelined integer square root, one result bit per stage.
// Depends on nothing.
module rnb_isqrt_pipe #(
  parameter int W = 58
) (
  input  logic             clk,
  input  logic             en,
  input  logic [W-1:0]     x_i,
  output logic [W/2-1:0]   root_o
);
  localparam int R  = W / 2;
  localparam int RW = R + 4;

  logic [W-1:0]  x_r [R];
  logic [RW-1:0] rem_r [R];
  logic [R-1:0]  root_r [R];
  logic [W-1:0]  x_nxt [R];
  logic [RW-1:0] rem_nxt [R];
  logic [R-1:0]  root_nxt [R];

  always_comb begin
    logic [W-1:0]  xs;
    logic [RW-1:0] rs;
    logic [R-1:0]  qs;
    logic [RW-1:0] cat;
    logic [RW-1:0] trial;
    for (int k = 0; k < R; k++) begin
      if (k == 0) begin
        xs = x_i;
        rs = '0;
        qs = '0;
      end else begin
        xs = x_r[k-1];
        rs = rem_r[k-1];
        qs = root_r[k-1];
      end
      cat   = {rs[RW-3:0], xs[W-1:W-2]};
      trial = {2'b00, qs, 2'b01};
      x_nxt[k] = {xs[W-3:0], 2'b00};
      if (cat >= trial) begin
        rem_nxt[k]  = cat - trial;
        root_nxt[k] = {qs[R-2:0], 1'b1};
      end else begin
        rem_nxt[k]  = cat;
        root_nxt[k] = {qs[R-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < R; k++) begin
        x_r[k]    <= x_nxt[k];
        rem_r[k]  <= rem_nxt[k];
        root_r[k] <= root_nxt[k];
      end
    end
  end

  assign root_o = root_r[R-1];
endmodule

// ===== src/rnb_div_pipe.sv =====
// Pipelined restoring divider with the quotient clamped to the Q1.14 unit.
// Depends on rnb_pkg for the quotient width and the clamp value.
module rnb_div_pipe #(
  parameter int NW = 43,
  parameter int DW = 29
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic [NW-1:0]            num_i,
  input  logic [DW-1:0]            den_i,
  output logic [rnb_pkg::Q_W-1:0]  quo_o
);
  localparam int QW = rnb_pkg::Q_W;
  localparam int PW = DW + QW;
  localparam int CW = ((NW > PW) ? NW : PW) + 1;

  logic [CW-1:0] rem_r [QW+1];
  logic [DW-1:0] den_r [QW+1];
  logic [QW-1:0] q_r [QW+1];
  logic          ovf_r [QW+1];
  logic [CW-1:0] rem_nxt [QW+1];
  logic [DW-1:0] den_nxt [QW+1];
  logic [QW-1:0] q_nxt [QW+1];
  logic          ovf_nxt [QW+1];
  logic [CW-1:0] lim;

  // Quotient exceeds the unit exactly when num >= (UNIT_ONE + 1) * den.
  assign lim = (CW'(den_i) << (QW - 1)) + CW'(den_i);

  always_comb begin
    logic [CW-1:0] sub;
    logic          ge;
    for (int k = 0; k <= QW; k++) begin
      if (k == 0) begin
        rem_nxt[k] = CW'(num_i);
        den_nxt[k] = den_i;
        q_nxt[k]   = '0;
        ovf_nxt[k] = (CW'(num_i) >= lim);
      end else begin
        sub = CW'(den_r[k-1]) << (QW - k);
        ge  = (rem_r[k-1] >= sub);
        rem_nxt[k] = ge ? (rem_r[k-1] - sub) : rem_r[k-1];
        den_nxt[k] = den_r[k-1];
        q_nxt[k]   = {q_r[k-1][QW-2:0], ge};
        ovf_nxt[k] = ovf_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k <= QW; k++) begin
        rem_r[k] <= rem_nxt[k];
        den_r[k] <= den_nxt[k];
        q_r[k]   <= q_nxt[k];
        ovf_r[k] <= ovf_nxt[k];
      end
    end
  end

  assign quo_o = ovf_r[QW] ? QW'(rnb_pkg::UNIT_ONE) : q_r[QW];
endmodule

// ===== src/rnb_group_lane.sv =====
// One radial group: difference to the pivot, length and unit vector.
// Depends on rnb_pkg, rnb_delay, rnb_isqrt_pipe and rnb_div_pipe.
module rnb_group_lane (
  input  logic                                clk,
  input  logic                                en,
  input  logic                                act_i,
  input  logic signed [rnb_pkg::COORD_W-1:0]  vx_i,
  input  logic signed [rnb_pkg::COORD_W-1:0]  vy_i,
  input  logic signed [rnb_pkg::COORD_W-1:0]  vz_i,
  input  logic [rnb_pkg::PIVOT_W-1:0]         pivot_i,
  output logic signed [rnb_pkg::NORM_W-1:0]   u_o [3]
);
  localparam int CW = rnb_pkg::COORD_W;
  localparam int MW = rnb_pkg::MAG1_W;

  logic signed [CW-1:0] v [3];
  logic [MW-1:0]        mag1_r [3];
  logic [2:0]           sgn1_r;
  logic                 act1_r;
  logic [2*MW-1:0]      sq2_r [3];
  logic [MW-1:0]        mag2_r [3];
  logic [2:0]           sgn2_r;
  logic                 act2_r;
  logic [rnb_pkg::SQS1_W-1:0] ssum3_r;
  rnb_pkg::lane_side_t  side3_r;
  rnb_pkg::lane_side_t  side_sq;
  logic [rnb_pkg::L1_W-1:0] len;
  logic [rnb_pkg::N1_W-1:0] num4_r [3];
  logic [rnb_pkg::L1_W-1:0] den4_r;
  rnb_pkg::sign_side_t  ss4_r;
  rnb_pkg::sign_side_t  ss_dv;
  logic [rnb_pkg::Q_W-1:0] quo [3];
  logic signed [rnb_pkg::NORM_W-1:0] u_r [3];

  assign v[0] = vx_i;
  assign v[1] = vy_i;
  assign v[2] = vz_i;

  always_ff @(posedge clk) begin
    logic signed [CW:0] d;
    if (en) begin
      for (int c = 0; c < 3; c++) begin
        d = {v[c][CW-1], v[c]} - {pivot_i[c*CW+CW-1], pivot_i[c*CW +: CW]};
        sgn1_r[c] <= d[CW];
        mag1_r[c] <= d[CW] ? MW'(-d) : d[MW-1:0];
        sq2_r[c]  <= mag1_r[c] * mag1_r[c];
        mag2_r[c] <= mag1_r[c];
      end
      act1_r  <= act_i;
      sgn2_r  <= sgn1_r;
      act2_r  <= act1_r;
      ssum3_r <= rnb_pkg::SQS1_W'(sq2_r[0]) + rnb_pkg::SQS1_W'(sq2_r[1])
               + rnb_pkg::SQS1_W'(sq2_r[2]);
      side3_r.nz  <= act2_r && ((sq2_r[0] | sq2_r[1] | sq2_r[2]) != '0);
      side3_r.sgn <= sgn2_r;
      for (int c = 0; c < 3; c++) begin
        side3_r.mag[c] <= mag2_r[c];
      end
    end
  end

  rnb_isqrt_pipe #(.W(rnb_pkg::SQ1_W)) u_sqrt (
    .clk(clk), .en(en), .x_i({ssum3_r, 16'd0}), .root_o(len)
  );

  rnb_delay #(.W($bits(rnb_pkg::lane_side_t)), .D(rnb_pkg::L1_W)) u_side (
    .clk(clk), .en(en), .d_i(side3_r), .d_o(side_sq)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 3; c++) begin
        num4_r[c] <= rnb_pkg::N1_W'({side_sq.mag[c], 22'd0})
                   + rnb_pkg::N1_W'(len[rnb_pkg::L1_W-1:1]);
      end
      den4_r    <= len;
      ss4_r.nz  <= side_sq.nz;
      ss4_r.sgn <= side_sq.sgn;
    end
  end

  for (genvar c = 0; c < 3; c++) begin : g_div
    rnb_div_pipe #(.NW(rnb_pkg::N1_W), .DW(rnb_pkg::L1_W)) u_div (
      .clk(clk), .en(en), .num_i(num4_r[c]), .den_i(den4_r), .quo_o(quo[c])
    );
  end

  rnb_delay #(.W($bits(rnb_pkg::sign_side_t)), .D(rnb_pkg::DIV_LAT)) u_sgn (
    .clk(clk), .en(en), .d_i(ss4_r), .d_o(ss_dv)
  );

  always_ff @(posedge clk) begin
    logic signed [rnb_pkg::NORM_W-1:0] q;
    if (en) begin
      for (int c = 0; c < 3; c++) begin
        q = signed'(rnb_pkg::NORM_W'(quo[c]));
        u_r[c] <= !ss_dv.nz ? '0 : (ss_dv.sgn[c] ? -q : q);
      end
    end
  end

  assign u_o = u_r;
endmodule

// ===== src/rnb_checker.sv =====
// Port-level checks for the radial normal blend top level, and the bind
// that attaches them. Depends on radial_normal_blend_top.
module rnb_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [95:0] in_tdata,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [55:0] out_tdata,
  input logic        cfg_we,
  input logic [2:0]  cfg_index,
  input logic [59:0] cfg_wdata
);
  // A result that waits keeps its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while waiting");

  // Without a contribution the normal must be zero.
  a_zero_normal: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[1] |-> out_tdata[49:2] == 48'd0)
    else $error("nonzero normal with found cleared");

  // A contribution needs an active radial group.
  a_found_uses: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[1] |-> out_tdata[0])
    else $error("found set without uses_radial");

  // Input is held off only while results are waiting.
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid)
    else $error("input stalled with no result pending");
endmodule

bind radial_normal_blend_top rnb_checker u_rnb_checker (.*);
